@@ design/lazy_sorted_id_table_core_defines.svh @@
// ----------------------------------------------------------------------------
// lazy_sorted_id_table_core_defines
// Assertion macros shared by the table core.
// ----------------------------------------------------------------------------
`ifndef LAZY_SORTED_ID_TABLE_CORE_DEFINES_SVH
`define LAZY_SORTED_ID_TABLE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define LSIT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsit assertion failed");
// next-cycle implication
`define LSIT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsit assertion failed");
`else
`define LSIT_ASSERT_IMPL(lbl, ante, cons)
`define LSIT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ design/lsit_pkg.sv @@
// ----------------------------------------------------------------------------
// lsit_pkg
// Types and codes for the lazy sorted identifier table.
// ----------------------------------------------------------------------------
package lsit_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int ID_W            = 32;
	localparam int HND_W           = 16;

	// operation codes
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	// status codes
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;

	typedef struct packed {
		logic [1:0]       op;
		logic [ID_W-1:0]  key_id;
		logic [HND_W-1:0] handle;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [HND_W-1:0] handle_out;
		logic [1:0]       status;
	} rsp_t;

	// one table entry as stored in the RAM
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [HND_W-1:0] hnd;
	} entry_t;

	// engine status toward the top level
	typedef struct packed {
		logic idle;
		logic res_valid;
		rsp_t res;
	} eng_stat_t;

endpackage

@@ design/lsit_ram.sv @@
// ----------------------------------------------------------------------------
// lsit_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lsit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/lsit_engine.sv @@
// ----------------------------------------------------------------------------
// lsit_engine
// Sequencer for add, remove/shift, lazy insertion sort and binary search,
// built around one id comparator and the table RAM port pair.
// ----------------------------------------------------------------------------
module lsit_engine import lsit_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  req_t          req,
	input  logic          res_take,
	output eng_stat_t     stat,
	output logic          ram_we,
	output logic [AW-1:0] ram_waddr,
	output entry_t        ram_wdata,
	output logic [AW-1:0] ram_raddr,
	input  entry_t        ram_rdata
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_RM_RD  = 4'd1;
	localparam logic [3:0] S_RM_CHK = 4'd2;
	localparam logic [3:0] S_SH_RD  = 4'd3;
	localparam logic [3:0] S_SH_WR  = 4'd4;
	localparam logic [3:0] S_SO_RDK = 4'd5;
	localparam logic [3:0] S_SO_KEY = 4'd6;
	localparam logic [3:0] S_SO_RDP = 4'd7;
	localparam logic [3:0] S_SO_CMP = 4'd8;
	localparam logic [3:0] S_SO_PUT = 4'd9;
	localparam logic [3:0] S_BS_RD  = 4'd10;
	localparam logic [3:0] S_BS_CMP = 4'd11;
	localparam logic [3:0] S_RESP   = 4'd12;

	localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);
	localparam logic [CW-1:0] ONE      = CW'(1);

	logic [3:0]       state_q, state_d;
	logic [CW-1:0]    count_q, count_d;
	logic             unsorted_q, unsorted_d;
	logic [ID_W-1:0]  key_q, key_d;
	logic [HND_W-1:0] hnd_q, hnd_d;
	entry_t           sort_q, sort_d;
	logic [CW-1:0]    idx_q, idx_d;   // i / lo
	logic [CW-1:0]    jdx_q, jdx_d;   // j / hi / k
	logic [AW-1:0]    mid_q, mid_d;
	rsp_t             res_q, res_d;

	// shared comparator: table id against the sort key or the search key
	logic [ID_W-1:0] cmp_b;
	logic            cmp_gt, cmp_lt;
	logic            sorting;
	logic [CW-1:0]   idx_p1, jdx_p1, jdx_m1;
	logic [CW:0]     mid_sum;

	assign sorting = (state_q == S_SO_CMP);
	assign cmp_b   = sorting ? sort_q.id : key_q;
	assign cmp_gt  = ram_rdata.id > cmp_b;
	assign cmp_lt  = ram_rdata.id < cmp_b;

	assign idx_p1  = idx_q + ONE;
	assign jdx_p1  = jdx_q + ONE;
	assign jdx_m1  = jdx_q - ONE;
	assign mid_sum = {1'b0, idx_q} + {1'b0, jdx_q} - {1'b0, ONE};

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		unsorted_d = unsorted_q;
		key_d      = key_q;
		hnd_d      = hnd_q;
		sort_d     = sort_q;
		idx_d      = idx_q;
		jdx_d      = jdx_q;
		mid_d      = mid_q;
		res_d      = res_q;
		ram_we     = 1'b0;
		ram_waddr  = count_q[AW-1:0];
		ram_wdata  = '{id: req.key_id, hnd: req.handle};
		ram_raddr  = idx_q[AW-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					key_d = req.key_id;
					hnd_d = req.handle;
					res_d = '{found: 1'b0, handle_out: '0, status: ST_DONE};
					unique case (req.op)
						OP_ADD: begin
							if (count_q == FULL_CNT) begin
								res_d.status = ST_FULL;
							end else begin
								ram_we     = 1'b1;
								count_d    = count_q + ONE;
								unsorted_d = 1'b1;
							end
							state_d = S_RESP;
						end
						OP_REMOVE: begin
							idx_d   = '0;
							state_d = S_RM_RD;
						end
						OP_SEARCH: begin
							if (unsorted_q) begin
								idx_d   = ONE;
								state_d = S_SO_RDK;
							end else begin
								idx_d   = '0;
								jdx_d   = count_q;
								state_d = S_BS_RD;
							end
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_RM_RD: begin
				if (idx_q < count_q) begin
					state_d = S_RM_CHK;
				end else begin
					res_d.status = ST_MISS;
					state_d      = S_RESP;
				end
			end
			S_RM_CHK: begin
				if (ram_rdata.hnd == hnd_q) begin
					jdx_d   = idx_q;
					state_d = S_SH_RD;
				end else begin
					idx_d   = idx_p1;
					state_d = S_RM_RD;
				end
			end
			S_SH_RD: begin
				ram_raddr = jdx_p1[AW-1:0];
				if (jdx_p1 < count_q) begin
					state_d = S_SH_WR;
				end else begin
					count_d     = count_q - ONE;
					res_d.found = 1'b1;
					state_d     = S_RESP;
				end
			end
			S_SH_WR: begin
				ram_we    = 1'b1;
				ram_waddr = jdx_q[AW-1:0];
				ram_wdata = ram_rdata;
				jdx_d     = jdx_p1;
				state_d   = S_SH_RD;
			end
			S_SO_RDK: begin
				if (idx_q < count_q) begin
					state_d = S_SO_KEY;
				end else begin
					unsorted_d = 1'b0;
					idx_d      = '0;
					jdx_d      = count_q;
					state_d    = S_BS_RD;
				end
			end
			S_SO_KEY: begin
				sort_d  = ram_rdata;
				jdx_d   = idx_q;
				state_d = S_SO_RDP;
			end
			S_SO_RDP: begin
				ram_raddr = jdx_m1[AW-1:0];
				state_d   = S_SO_CMP;
			end
			S_SO_CMP: begin
				ram_we    = 1'b1;
				ram_waddr = jdx_q[AW-1:0];
				if (cmp_gt) begin
					// larger neighbor moves up one slot
					ram_wdata = ram_rdata;
					jdx_d     = jdx_m1;
					state_d   = (jdx_q == ONE) ? S_SO_PUT : S_SO_RDP;
				end else begin
					ram_wdata = sort_q;
					idx_d     = idx_p1;
					state_d   = S_SO_RDK;
				end
			end
			S_SO_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = jdx_q[AW-1:0];
				ram_wdata = sort_q;
				idx_d     = idx_p1;
				state_d   = S_SO_RDK;
			end
			S_BS_RD: begin
				ram_raddr = mid_sum[AW:1];
				mid_d     = mid_sum[AW:1];
				if (idx_q < jdx_q) begin
					state_d = S_BS_CMP;
				end else begin
					res_d.status = ST_MISS;
					state_d      = S_RESP;
				end
			end
			S_BS_CMP: begin
				priority if (cmp_lt) begin
					idx_d   = CW'(mid_q) + ONE;
					state_d = S_BS_RD;
				end else if (cmp_gt) begin
					jdx_d   = CW'(mid_q);
					state_d = S_BS_RD;
				end else begin
					res_d.found      = 1'b1;
					res_d.handle_out = ram_rdata.hnd;
					state_d          = S_RESP;
				end
			end
			S_RESP: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			unsorted_q <= 1'b1;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			unsorted_q <= unsorted_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q  <= key_d;
		hnd_q  <= hnd_d;
		sort_q <= sort_d;
		idx_q  <= idx_d;
		jdx_q  <= jdx_d;
		mid_q  <= mid_d;
		res_q  <= res_d;
	end

	assign stat.idle      = (state_q == S_IDLE);
	assign stat.res_valid = (state_q == S_RESP);
	assign stat.res       = res_q;

endmodule

@@ design/lazy_sorted_id_table_core.sv @@
// ----------------------------------------------------------------------------
// lazy_sorted_id_table_core
// Identifier/handle table with lazy insertion sort and binary search.
// ----------------------------------------------------------------------------
// One request is worked at a time; req_stall stays high from the accepting
// edge until the engine has handed its result to the output register. All
// work runs through a single table RAM (one write port, one registered read
// port) and one 32-bit id comparator, so the cost in cycles follows the
// number of RAM reads: add writes the new entry at the end of the table;
// remove scans entries up to the match, then shifts each later entry down
// one slot; a search on a sorted table runs a binary search. The first
// search after any add also sorts, at a cost that grows with how far the
// entries must move (worst on reversed data), paid once and then amortized
// over later searches. The result sits in an output register, so the next
// request is taken while the last result is still stalled. Table contents
// need no clearing after reset.
// ----------------------------------------------------------------------------
`include "lazy_sorted_id_table_core_defines.svh"

module lazy_sorted_id_table_core import lsit_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// request channel
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	// response channel
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);

	eng_stat_t     eng_st;
	logic          req_xfer;
	logic          res_take;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	entry_t        ram_wdata;
	entry_t        ram_rdata;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	// request transfer only while the engine sits idle
	assign req_stall = !eng_st.idle;
	assign req_xfer  = req_valid && !req_stall;

	// output slot is free when empty or being drained this cycle
	assign res_take = !rsp_valid_q || !rsp_stall;

	lsit_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lsit_engine #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req_xfer),
		.req       (req),
		.res_take  (res_take),
		.stat      (eng_st),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (eng_st.res_valid && res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_st.res_valid && res_take) begin
			rsp_q <= eng_st.res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// an accepted request always leaves the engine busy on the next edge
	`LSIT_ASSERT_NEXT(a_busy_after_req, req_xfer, req_stall)
	// engine never offers a result while idle
	`LSIT_ASSERT_IMPL(a_idle_no_result, eng_st.idle, !eng_st.res_valid)
	// a hit always reports done
	`LSIT_ASSERT_IMPL(a_found_done, rsp_valid_q && rsp_q.found, rsp_q.status == ST_DONE)
	// a nonzero handle only comes with a hit
	`LSIT_ASSERT_IMPL(a_handle_needs_hit, rsp_valid_q && (rsp_q.handle_out != '0),
		rsp_q.found)

endmodule
